@@ rtl/core/axfp_pkg.sv @@
package axfp_pkg;

   localparam int ACC_W   = 31;
   localparam int VALUE_W = 32;
   localparam int SCALE_W = 14;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [ACC_W-1:0]   ACC_MAX    = 31'h7FFF_FFFF;
   localparam logic [SCALE_W-1:0] FRAC_SCALE = 14'd10000;

   localparam logic [1:0] COORD_X    = 2'd0;
   localparam logic [1:0] COORD_LAST = 2'd2;

   typedef enum logic [4:0] {
      PH_START = 5'b00001,
      PH_LEAD  = 5'b00010,
      PH_INT   = 5'b00100,
      PH_FRAC  = 5'b01000,
      PH_SEP   = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic             negative;
      logic [ACC_W-1:0] int_acc;
      logic [ACC_W-1:0] frac_acc;
      logic [1:0]       coord;
      logic             ended;
   } parse_state_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // acc * 10 + d, clamped to the largest positive value
   function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] d);
      logic [ACC_W+3:0] n;
      n = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, d};
      if (n > {4'd0, ACC_MAX}) begin
         return ACC_MAX;
      end
      return n[ACC_W-1:0];
   endfunction

endpackage

@@ rtl/core/axfp_value.sv @@
module axfp_value
   import axfp_pkg::*;
(
   input  parse_state_type            cur,
   output logic signed [VALUE_W-1:0]  fixed_value
);

   logic [ACC_W+SCALE_W-1:0] prod;
   logic [ACC_W+SCALE_W:0]   mag;
   logic [ACC_W-1:0]         mag_sat;
   logic [VALUE_W-1:0]       mag_ext;

   always_comb begin
      prod    = {{SCALE_W{1'b0}}, cur.int_acc} * {{ACC_W{1'b0}}, FRAC_SCALE};
      mag     = {1'b0, prod} + {{(SCALE_W+1){1'b0}}, cur.frac_acc};
      mag_sat = (mag > {{(SCALE_W+1){1'b0}}, ACC_MAX}) ? ACC_MAX : mag[ACC_W-1:0];
      mag_ext = {1'b0, mag_sat};
      fixed_value = cur.negative ? signed'(-mag_ext) : signed'(mag_ext);
   end

endmodule

@@ rtl/core/axfp_step.sv @@
module axfp_step
   import axfp_pkg::*;
(
   input  parse_state_type cur,
   input  logic [7:0]      text_byte,
   output parse_state_type nxt,
   output logic            emit
);

   // number start: spaces skipped, optional sign, else into the digits
   function automatic parse_state_type apply_lead(input parse_state_type s,
                                                  input logic [7:0] c);
      parse_state_type r;
      r = s;
      if (c == CHAR_SPACE) begin
         r.phase = PH_LEAD;
      end else begin
         r.negative = (c == CHAR_MINUS);
         r.frac_acc = '0;
         r.int_acc  = '0;
         if (c == CHAR_MINUS) begin
            r.phase = PH_INT;
         end else if (is_digit(c)) begin
            r.int_acc = {{(ACC_W-4){1'b0}}, c[3:0]};
            r.phase   = PH_INT;
         end else begin
            // a non-digit here is the point of a digit-free number
            r.phase = PH_FRAC;
         end
      end
      return r;
   endfunction

   function automatic parse_state_type apply_start(input parse_state_type s,
                                                   input logic [7:0] c);
      parse_state_type r;
      r = s;
      if (c == CHAR_NUL) begin
         r.phase = PH_START;
         r.ended = 1'b1;
      end else begin
         r = apply_lead(s, c);
      end
      return r;
   endfunction

   function automatic parse_state_type apply_sep(input parse_state_type s,
                                                 input logic [7:0] c);
      parse_state_type r;
      r = s;
      if (c inside {CHAR_SPACE, CHAR_CR, CHAR_LF}) begin
         r.phase = PH_SEP;
      end else if (s.coord == COORD_X) begin
         r = apply_start(s, c);
      end else begin
         r = apply_lead(s, c);
      end
      return r;
   endfunction

   parse_state_type after_emit;

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      after_emit = cur;
      after_emit.coord = (cur.coord >= COORD_LAST) ? COORD_X : cur.coord + 2'd1;
      if (!cur.ended) begin
         case (cur.phase)
            PH_START: begin
               nxt = apply_start(cur, text_byte);
            end
            PH_LEAD: begin
               nxt = apply_lead(cur, text_byte);
            end
            PH_INT: begin
               if (is_digit(text_byte)) begin
                  nxt.int_acc = acc_digit(cur.int_acc, text_byte[3:0]);
               end else begin
                  nxt.phase = PH_FRAC;
               end
            end
            PH_FRAC: begin
               if (is_digit(text_byte)) begin
                  nxt.frac_acc = acc_digit(cur.frac_acc, text_byte[3:0]);
               end else begin
                  // the ending byte also starts the separator
                  emit = 1'b1;
                  nxt  = apply_sep(after_emit, text_byte);
               end
            end
            default: begin
               nxt = apply_sep(cur, text_byte);
            end
         endcase
      end
   end

endmodule

@@ rtl/core/ascii_xyz_fixed_point_parser_core.sv @@
// Parses an ASCII x y z point-cloud text stream, one byte per req word, into signed
// numbers scaled by 10000 (32-bit, magnitude saturated to 2147483647), each tagged with
// its coordinate index and an end-of-point flag on the rsp word. One byte is accepted
// every clock unless a value waits on a stalled rsp word; the byte that ends a number
// goes through the input register, and its value through the result register. That rate
// is set by the parse state register, which takes one byte's update per cycle,
// including the fixed-point scale multiply on the terminating byte. A zero byte at the
// start of a point ends the stream; every later byte is taken and dropped until reset.
module ascii_xyz_fixed_point_parser_core
   import axfp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_fixed_value,
   output logic [1:0]                 rsp_coord_index,
   output logic                       rsp_point_done
);

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   parse_state_type           state_ff;
   parse_state_type           state_in;
   logic                      out_valid_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic [1:0]                out_coord_ff;
   logic                      out_done_ff;

   logic                      emit;
   logic signed [VALUE_W-1:0] value;
   logic                      out_free;
   logic                      fire;
   logic                      req_take;

   axfp_step u_step (
      .cur       (state_ff),
      .text_byte (in_byte_ff),
      .nxt       (state_in),
      .emit      (emit)
   );

   axfp_value u_value (
      .cur         (state_ff),
      .fixed_value (value)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   // a word that yields no value never waits on the output side
   assign fire      = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase    <= PH_START;
         state_ff.negative <= 1'b0;
         state_ff.int_acc  <= '0;
         state_ff.frac_acc <= '0;
         state_ff.coord    <= COORD_X;
         state_ff.ended    <= 1'b0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire && emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_value_ff <= value;
         out_coord_ff <= state_ff.coord;
         out_done_ff  <= (state_ff.coord == COORD_LAST);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_fixed_value = out_value_ff;
   assign rsp_coord_index = out_coord_ff;
   assign rsp_point_done  = out_done_ff;

endmodule

@@ rtl/core/axfp_checker.sv @@
module axfp_checker
   import axfp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [VALUE_W-1:0] rsp_fixed_value,
   input logic [1:0]                rsp_coord_index,
   input logic                      rsp_point_done
);

   // no word is left over from before reset
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word present after reset");

   // end-of-point flag marks exactly the z coordinate
   a_done_is_z : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_point_done == 1'b1) == (rsp_coord_index == COORD_LAST)))
      else $error("point_done does not match coord_index");

   // saturation keeps the value in the symmetric range; the coordinate index never reaches 3
   a_value_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fixed_value != 32'sh8000_0000) && (rsp_coord_index != 2'd3))
      else $error("rsp word out of range");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fixed_value)
         && $stable(rsp_coord_index) && $stable(rsp_point_done))
      else $error("stalled rsp word changed");

endmodule

bind ascii_xyz_fixed_point_parser_core axfp_checker u_axfp_checker (.*);
